>>> sv/dceb_pkg.sv
package dceb_pkg;

  localparam int unsigned ADDR_W   = 19;
  localparam int unsigned EADDR_W  = ADDR_W + 1;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_LEAD_IN     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_TOTAL = 2'd1;

  localparam logic [6:0] MAX_TRACKS = 7'd99;

  localparam logic [EADDR_W-1:0] FRAME_OFFSET = 20'd150;

  localparam logic [7:0] CTL_AUDIO         = 8'h01;
  localparam logic [7:0] CTL_DATA          = 8'h41;
  localparam logic [7:0] FORM_AUDIO        = 8'h00;
  localparam logic [7:0] FORM_DATA         = 8'h10;
  localparam logic [7:0] FORM_DATA_LEADIN  = 8'h14;
  localparam logic [7:0] FORM_LEADIN_AUDIO = 8'h01;
  localparam logic [7:0] FORM_LEADOUT      = 8'h01;
  localparam logic [7:0] TRACK_LEADIN      = 8'h00;
  localparam logic [7:0] TRACK_ONE         = 8'h01;
  localparam logic [7:0] TRACK_LEADOUT     = 8'hAA;

  // Exact reciprocals: x / 75 for x < 2^20, x / 60 for x < 2^13
  localparam logic [20:0] RECIP_75 = 21'd1789570;
  localparam int unsigned SHIFT_75 = 27;
  localparam logic [13:0] RECIP_60 = 14'd8739;
  localparam int unsigned SHIFT_60 = 19;

  // Pending entry slots, emitted lowest first
  localparam int unsigned SLOT_LEADIN  = 0;
  localparam int unsigned SLOT_PREGAP1 = 1;
  localparam int unsigned SLOT_IDX0    = 2;
  localparam int unsigned SLOT_IDX1    = 3;
  localparam int unsigned SLOT_LEADOUT = 4;
  localparam int unsigned NUM_SLOTS    = 5;

  typedef struct packed {
    logic              track_is_data;
    logic              has_pregap;
    logic [ADDR_W-1:0] pregap_address;
    logic [ADDR_W-1:0] start_address;
    logic              final_track;
  } in_item_t;

  typedef struct packed {
    logic [7:0] control_address;
    logic [7:0] track_bcd;
    logic       index_byte;
    logic [7:0] data_form;
    logic       copy_byte;
    logic [7:0] minute_bcd;
    logic [6:0] second_bcd;
    logic [6:0] frame_bcd;
    logic       entry_last;
  } out_item_t;

  // Entry fields that pass through the time conversion untouched
  typedef struct packed {
    logic [7:0] ctl;
    logic [7:0] trk;
    logic       idx;
    logic [7:0] form;
    logic       last;
  } entry_meta_t;

  typedef struct packed {
    entry_meta_t        meta;
    logic [EADDR_W-1:0] addr;
  } entry_t;

  // Binary to packed BCD for values below 100, tens by reciprocal of 10
  function automatic logic [7:0] to_bcd(input logic [6:0] v);
    logic [17:0] p;
    logic [3:0]  tens;
    logic [6:0]  units;
    p     = 18'(v) * 18'd205;
    tens  = p[14:11];
    units = v - ({3'b000, tens} * 7'd10);
    return {tens, units[3:0]};
  endfunction

endpackage

>>> sv/dceb_front.sv
module dceb_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [dceb_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [dceb_pkg::ADDR_W-1:0]   cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  dceb_pkg::in_item_t            in_item_i,
  output logic                          push_valid_o,
  input  logic                          push_ready_i,
  output dceb_pkg::entry_t              push_entry_o
);

  logic [dceb_pkg::ADDR_W-1:0]    lead_in_q;
  logic [dceb_pkg::ADDR_W-1:0]    total_q;
  logic [6:0]                     cnt_q, cnt_d;
  logic                           first_q, first_d;
  logic [dceb_pkg::NUM_SLOTS-1:0] pend_q, pend_d;
  logic [dceb_pkg::NUM_SLOTS-1:0] sel;
  dceb_pkg::in_item_t             item_q;
  logic [7:0]                     trk_q;
  logic [6:0]                     cnt_inc;
  logic                           busy, push, last, accept;
  logic [7:0]                     ctl, form;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lead_in_q <= '0;
      total_q   <= '0;
    end else if (cfg_we_i) begin
      if (cfg_index_i == dceb_pkg::CFG_LEAD_IN) begin
        lead_in_q <= cfg_data_i;
      end else if (cfg_index_i == dceb_pkg::CFG_FRAME_TOTAL) begin
        total_q <= cfg_data_i;
      end
    end
  end

  always_comb begin
    busy       = |pend_q;
    sel        = pend_q & (~pend_q + 5'd1);
    last       = (pend_q & ~sel) == '0;
    push       = busy && push_ready_i;
    in_stall_o = busy && !(push && last);
    accept     = in_valid_i && !in_stall_o;
    cnt_inc    = (cnt_q < dceb_pkg::MAX_TRACKS) ? cnt_q + 7'd1 : cnt_q;

    pend_d  = push ? (pend_q & ~sel) : pend_q;
    cnt_d   = cnt_q;
    first_d = first_q;
    if (accept) begin
      pend_d                          = '0;
      pend_d[dceb_pkg::SLOT_LEADIN]   = first_q;
      pend_d[dceb_pkg::SLOT_PREGAP1]  = first_q;
      pend_d[dceb_pkg::SLOT_IDX0]     = in_item_i.has_pregap;
      pend_d[dceb_pkg::SLOT_IDX1]     = 1'b1;
      pend_d[dceb_pkg::SLOT_LEADOUT]  = in_item_i.final_track;
      // Final track closes the sheet: restart numbering
      cnt_d   = in_item_i.final_track ? 7'd0 : cnt_inc;
      first_d = in_item_i.final_track;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q  <= '0;
      cnt_q   <= '0;
      first_q <= 1'b1;
    end else begin
      pend_q  <= pend_d;
      cnt_q   <= cnt_d;
      first_q <= first_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_item_i;
      trk_q  <= dceb_pkg::to_bcd(cnt_inc);
    end
  end

  always_comb begin
    ctl  = item_q.track_is_data ? dceb_pkg::CTL_DATA : dceb_pkg::CTL_AUDIO;
    form = item_q.track_is_data ? dceb_pkg::FORM_DATA : dceb_pkg::FORM_AUDIO;

    push_valid_o           = busy;
    push_entry_o.meta.last = last;
    push_entry_o.meta.ctl  = ctl;
    push_entry_o.meta.trk  = trk_q;
    push_entry_o.meta.idx  = 1'b1;
    push_entry_o.meta.form = form;
    push_entry_o.addr      = {1'b0, item_q.start_address} + dceb_pkg::FRAME_OFFSET;

    if (sel[dceb_pkg::SLOT_LEADIN]) begin
      push_entry_o.meta.trk  = dceb_pkg::TRACK_LEADIN;
      push_entry_o.meta.idx  = 1'b0;
      push_entry_o.meta.form = item_q.track_is_data ? dceb_pkg::FORM_DATA_LEADIN
                                                    : dceb_pkg::FORM_LEADIN_AUDIO;
      push_entry_o.addr      = {1'b0, lead_in_q};
    end else if (sel[dceb_pkg::SLOT_PREGAP1]) begin
      push_entry_o.meta.trk  = dceb_pkg::TRACK_ONE;
      push_entry_o.meta.idx  = 1'b0;
      push_entry_o.addr      = '0;
    end else if (sel[dceb_pkg::SLOT_IDX0]) begin
      push_entry_o.meta.idx  = 1'b0;
      push_entry_o.addr      = {1'b0, item_q.pregap_address} + dceb_pkg::FRAME_OFFSET;
    end else if (sel[dceb_pkg::SLOT_LEADOUT]) begin
      push_entry_o.meta.ctl  = dceb_pkg::CTL_AUDIO;
      push_entry_o.meta.trk  = dceb_pkg::TRACK_LEADOUT;
      push_entry_o.meta.form = dceb_pkg::FORM_LEADOUT;
      push_entry_o.addr      = {1'b0, total_q} + dceb_pkg::FRAME_OFFSET;
    end
  end

endmodule

>>> sv/dceb_queue.sv
module dceb_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  dceb_pkg::entry_t push_entry_i,
  output logic             pop_valid_o,
  input  logic             pop_i,
  output dceb_pkg::entry_t pop_entry_o
);

  dceb_pkg::entry_t mem_q [2];
  logic             wr_q, rd_q;
  logic [1:0]       cnt_q;
  logic             do_push, do_pop;

  assign push_ready_o = cnt_q != 2'd2;
  assign pop_valid_o  = cnt_q != 2'd0;
  assign pop_entry_o  = mem_q[rd_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) begin
        wr_q <= ~wr_q;
      end
      if (do_pop) begin
        rd_q <= ~rd_q;
      end
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_entry_i;
    end
  end

endmodule

>>> sv/dceb_back.sv
module dceb_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 pop_valid_i,
  output logic                 pop_o,
  input  dceb_pkg::entry_t     pop_entry_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output dceb_pkg::out_item_t  out_item_o
);

  // Stage 1: frames total / 75
  logic                                v1_q;
  dceb_pkg::entry_meta_t               m1_q;
  logic [dceb_pkg::EADDR_W-1:0]        a1_q;
  logic [12:0]                         q1_q;
  // Stage 2: frame remainder, minutes
  logic                                v2_q;
  dceb_pkg::entry_meta_t               m2_q;
  logic [12:0]                         q2_q;
  logic [6:0]                          mn2_q, f2_q;
  // Stage 3: seconds
  logic                                v3_q;
  dceb_pkg::entry_meta_t               m3_q;
  logic [6:0]                          mn3_q, f3_q;
  logic [5:0]                          s3_q;
  // Output register
  logic                                vo_q;
  dceb_pkg::out_item_t                 out_q;

  logic                                rdy1, rdy2, rdy3, rdyo;
  logic [40:0]                         p75;
  logic [26:0]                         p60;
  logic [dceb_pkg::EADDR_W-1:0]        f_full;
  logic [12:0]                         s_full;
  logic [7:0]                          mn_bcd, s_bcd, f_bcd;

  assign rdyo  = !vo_q || !out_stall_i;
  assign rdy3  = !v3_q || rdyo;
  assign rdy2  = !v2_q || rdy3;
  assign rdy1  = !v1_q || rdy2;
  assign pop_o = pop_valid_i && rdy1;

  assign p75    = 41'(pop_entry_i.addr) * 41'(dceb_pkg::RECIP_75);
  assign p60    = 27'(q1_q) * 27'(dceb_pkg::RECIP_60);
  assign f_full = a1_q - (20'(q1_q) * 20'd75);
  assign s_full = q2_q - (13'(mn2_q) * 13'd60);
  assign mn_bcd = dceb_pkg::to_bcd(mn3_q);
  assign s_bcd  = dceb_pkg::to_bcd({1'b0, s3_q});
  assign f_bcd  = dceb_pkg::to_bcd(f3_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= pop_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdyo) vo_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      m1_q <= pop_entry_i.meta;
      a1_q <= pop_entry_i.addr;
      q1_q <= p75[dceb_pkg::SHIFT_75 +: 13];
    end
    if (rdy2 && v1_q) begin
      m2_q  <= m1_q;
      q2_q  <= q1_q;
      mn2_q <= p60[dceb_pkg::SHIFT_60 +: 7];
      f2_q  <= f_full[6:0];
    end
    if (rdy3 && v2_q) begin
      m3_q  <= m2_q;
      mn3_q <= mn2_q;
      f3_q  <= f2_q;
      s3_q  <= s_full[5:0];
    end
    if (rdyo && v3_q) begin
      out_q.control_address <= m3_q.ctl;
      out_q.track_bcd       <= m3_q.trk;
      out_q.index_byte      <= m3_q.idx;
      out_q.data_form       <= m3_q.form;
      out_q.copy_byte       <= 1'b0;
      out_q.minute_bcd      <= mn_bcd;
      out_q.second_bcd      <= s_bcd[6:0];
      out_q.frame_bcd       <= f_bcd[6:0];
      out_q.entry_last      <= m3_q.last;
    end
  end

  assign out_valid_o = vo_q;
  assign out_item_o  = out_q;

endmodule

>>> sv/disc_cue_entry_builder_core.sv
// Channel  | Direction | Signals
// ---------+-----------+-------------------------------------------------
// input    | in        | in_valid_i, in_stall_o, in_item_i (track descriptor)
// output   | out       | out_valid_o, out_stall_i, out_item_o (cue entry)
// config   | in        | cfg_we_i, cfg_index_i, cfg_data_i (write only)
//
// One cue entry leaves per cycle unless the output stalls. An item makes
// 1 to 5 entries, queued one a cycle by the front sequencer while the
// queue has room. Next item is taken in the cycle its last entry is queued.
// Popped entries pass conversion stages 1, 2, 3 and the output register.
// Reset clears control state; both registers read zero until written.
// Output stall backs up through the pipeline and the two-entry queue.
module disc_cue_entry_builder_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [dceb_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [dceb_pkg::ADDR_W-1:0]    cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  dceb_pkg::in_item_t             in_item_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output dceb_pkg::out_item_t            out_item_o
);

  logic             push_valid, push_ready, pop_valid, pop;
  dceb_pkg::entry_t push_entry, pop_entry;

  dceb_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_item_i    (in_item_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_entry_o (push_entry)
  );

  dceb_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_entry_i (push_entry),
    .pop_valid_o  (pop_valid),
    .pop_i        (pop),
    .pop_entry_o  (pop_entry)
  );

  dceb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_o       (pop),
    .pop_entry_i (pop_entry),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule
